/* hdl/lwv_pkg.sv */
// ----------------------------------------------------------------------------
// lwv_pkg
// Shared constants and types of the 5x5 local variance filter.
// ----------------------------------------------------------------------------
`default_nettype none
package lwv_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = COL_W + 1;
    localparam int ROW_W      = 16;
    localparam int STORE_ROWS = 5;
    localparam int SLOT_W     = 3;
    localparam int RAM_DEPTH  = STORE_ROWS * MAX_WIDTH;
    localparam int PIX_W      = 8;
    localparam int FRAC_BITS  = 8;
    localparam int VAR_W      = 23;
    localparam int SUM_W      = 13;
    localparam int SQ_W       = 21;
    localparam int NUM_W      = 26;
    localparam int DIVD_W     = NUM_W + FRAC_BITS;
    localparam int DEN_W      = 10;
    localparam int CNT_W      = 5;
    localparam int IT_W       = $clog2(DIVD_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(MAX_WIDTH);
    localparam logic [ROW_W-1:0] HEIGHT_RESET = 16'd512;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] slot;
        logic              last_row;
        logic              last_col;
    } t_job;

    typedef struct packed {
        logic [WID_W-1:0] width;
        logic [ROW_W-1:0] height;
    } t_dims;
endpackage
`default_nettype wire

/* hdl/lwv_pix_if.sv */
// ----------------------------------------------------------------------------
// lwv_pix_if
// Pixel request channel.
// ----------------------------------------------------------------------------
`default_nettype none
interface lwv_pix_if;
    logic                      valid;
    logic                      ready;
    logic [lwv_pkg::PIX_W-1:0] pixel_value;
    modport source(output valid, output pixel_value, input ready);
    modport sink(input valid, input pixel_value, output ready);
endinterface
`default_nettype wire

/* hdl/lwv_res_if.sv */
// ----------------------------------------------------------------------------
// lwv_res_if
// Variance result request channel.
// ----------------------------------------------------------------------------
`default_nettype none
interface lwv_res_if;
    logic                      valid;
    logic                      ready;
    logic [lwv_pkg::ROW_W-1:0] out_row;
    logic [lwv_pkg::COL_W-1:0] out_col;
    logic [lwv_pkg::VAR_W-1:0] variance_fixed;
    logic                      frame_last;
    modport source(output valid, output out_row, output out_col,
                   output variance_fixed, output frame_last, input ready);
    modport sink(input valid, input out_row, input out_col,
                 input variance_fixed, input frame_last, output ready);
endinterface
`default_nettype wire

/* hdl/local_window_variance_5x5.sv */
// ----------------------------------------------------------------------------
// local_window_variance_5x5
// Streaming 5x5 local variance filter with clipped borders.
// ----------------------------------------------------------------------------
// a pixel that completes no window passes through S_IDLE and S_WR in the back end
// each result runs S_SETUP, S_RD/S_AC per cell, S_MUL, S_SUB, S_DIV, S_FIN, S_WAIT
// so a last-column pixel gives up to 3 results, up to 9 at the frame end
// throughput set by the serial cell reads of the line store and the bit-serial divider
// synchronous active-low reset: 1024x512 size, position cleared, line store not cleared
`default_nettype none
module local_window_variance_5x5 (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lwv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lwv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lwv_pix_if.sink                             i_pix,
    lwv_res_if.source                           o_res
);
    import lwv_pkg::*;

    logic  fq_valid, fq_ready, qb_valid, qb_ready;
    t_job  fq_job, qb_job;
    t_dims dims;

    lwv_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .o_job_valid(fq_valid),
        .i_job_ready(fq_ready),
        .o_job      (fq_job),
        .o_dims     (dims)
    );

    lwv_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(fq_valid),
        .o_ready(fq_ready),
        .i_job  (fq_job),
        .o_valid(qb_valid),
        .i_ready(qb_ready),
        .o_job  (qb_job)
    );

    lwv_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(qb_valid),
        .o_job_ready(qb_ready),
        .i_job      (qb_job),
        .i_dims     (dims),
        .o_res      (o_res)
    );
endmodule
`default_nettype wire

/* hdl/lwv_ram.sv */
// ----------------------------------------------------------------------------
// lwv_ram
// Generic simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module lwv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hdl/lwv_front.sv */
// ----------------------------------------------------------------------------
// lwv_front
// Config registers, raster position tracking and job classification.
// ----------------------------------------------------------------------------
`default_nettype none
module lwv_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lwv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lwv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lwv_pix_if.sink                             i_pix,
    output logic                                o_job_valid,
    input  wire logic                           i_job_ready,
    output lwv_pkg::t_job                       o_job,
    output lwv_pkg::t_dims                      o_dims
);
    import lwv_pkg::*;

    logic [WID_W-1:0]  r_width;
    logic [ROW_W-1:0]  r_height;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [SLOT_W-1:0] r_slot;

    logic [WID_W-1:0]  w_eff;
    logic [ROW_W-1:0]  h_eff;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [SLOT_W-1:0] cur_slot;
    logic              last_row;
    logic              last_col;
    logic              cfg_hit;

    always_comb begin
        if (r_width == '0) begin
            w_eff = WID_W'(1);
        end else if (r_width > WID_W'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        h_eff    = (r_height == '0) ? ROW_W'(1) : r_height;
        cur_col  = ({1'b0, r_col} >= w_eff) ? '0 : r_col;
        cur_row  = (r_row >= h_eff) ? '0 : r_row;
        cur_slot = (r_row >= h_eff) ? '0 : r_slot;
        last_row = (cur_row == h_eff - ROW_W'(1));
        last_col = ({1'b0, cur_col} == w_eff - WID_W'(1));
        cfg_hit  = i_cfg_we && (i_cfg_idx == CFG_WIDTH || i_cfg_idx == CFG_HEIGHT);
    end

    assign i_pix.ready      = i_job_ready;
    assign o_job_valid      = i_pix.valid;
    assign o_job.pixel      = i_pix.pixel_value;
    assign o_job.row        = cur_row;
    assign o_job.col        = cur_col;
    assign o_job.slot       = cur_slot;
    assign o_job.last_row   = last_row;
    assign o_job.last_col   = last_col;
    assign o_dims.width     = w_eff;
    assign o_dims.height    = h_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_row    <= '0;
            r_col    <= '0;
            r_slot   <= '0;
        end else if (cfg_hit) begin
            if (i_cfg_idx == CFG_WIDTH) begin
                r_width <= i_cfg_data[WID_W-1:0];
            end else begin
                r_height <= i_cfg_data[ROW_W-1:0];
            end
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (i_pix.valid && i_job_ready) begin
            if (last_col) begin
                r_col <= '0;
                if (last_row) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= cur_row + ROW_W'(1);
                    r_slot <= (cur_slot == SLOT_W'(STORE_ROWS - 1)) ? '0
                              : cur_slot + SLOT_W'(1);
                end
            end else begin
                r_col  <= cur_col + COL_W'(1);
                r_row  <= cur_row;
                r_slot <= cur_slot;
            end
        end
    end
endmodule
`default_nettype wire

/* hdl/lwv_queue.sv */
// ----------------------------------------------------------------------------
// lwv_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module lwv_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  lwv_pkg::t_job i_job,
    output logic         o_valid,
    input  wire logic    i_ready,
    output lwv_pkg::t_job o_job
);
    import lwv_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

/* hdl/lwv_back.sv */
// ----------------------------------------------------------------------------
// lwv_back
// Line store update, window accumulation, serial divide and result output.
// ----------------------------------------------------------------------------
`default_nettype none
module lwv_back (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_job_valid,
    output logic           o_job_ready,
    input  lwv_pkg::t_job  i_job,
    input  lwv_pkg::t_dims i_dims,
    lwv_res_if.source      o_res
);
    import lwv_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_WR, S_SETUP, S_RD, S_AC, S_MUL, S_SUB, S_DIV, S_FIN, S_WAIT
    } t_state;

    localparam int ADDR_W = $clog2(RAM_DEPTH);

    t_state            r_state;
    t_job              r_job;
    logic [ROW_W-1:0]  r_r, r_rb, r_y, r_yend;
    logic [COL_W-1:0]  r_c, r_ca, r_cb, r_x, r_x0, r_x1;
    logic [SLOT_W-1:0] r_yslot;
    logic [SUM_W-1:0]  r_s;
    logic [SQ_W-1:0]   r_q;
    logic [CNT_W-1:0]  r_cnt;
    logic [NUM_W-1:0]  r_p1, r_p2;
    logic [DIVD_W-1:0] r_dv;
    logic [DEN_W-1:0]  r_rem, r_den;
    logic [IT_W-1:0]   r_it;
    logic              r_out_v;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;
    logic [VAR_W-1:0]  r_out_var;
    logic              r_out_last;

    logic [PIX_W-1:0]  rd_data;
    logic              ram_we;
    logic [ADDR_W-1:0] waddr, raddr;

    logic [ROW_W-1:0]  r0, r1;
    logic [COL_W-1:0]  c0, c1;
    logic [ROW_W:0]    rp2;
    logic [WID_W-1:0]  cp2;
    logic [SLOT_W-1:0] slot_dist, slot0;
    logic [DEN_W:0]    rem2;

    assign ram_we = (r_state == S_WR);
    assign waddr  = ADDR_W'({r_job.slot, r_job.col});
    assign raddr  = ADDR_W'({r_yslot, r_x});

    lwv_ram #(.WIDTH(PIX_W), .DEPTH(RAM_DEPTH)) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(waddr),
        .i_wdata(r_job.pixel),
        .i_raddr(raddr),
        .o_rdata(rd_data)
    );

    always_comb begin
        r0        = (r_r >= ROW_W'(2)) ? r_r - ROW_W'(2) : '0;
        rp2       = {1'b0, r_r} + (ROW_W+1)'(2);
        r1        = (rp2 < {1'b0, i_dims.height}) ? rp2[ROW_W-1:0]
                    : i_dims.height - ROW_W'(1);
        c0        = (r_c >= COL_W'(2)) ? r_c - COL_W'(2) : '0;
        cp2       = {1'b0, r_c} + WID_W'(2);
        c1        = (cp2 < i_dims.width) ? cp2[COL_W-1:0]
                    : COL_W'(i_dims.width - WID_W'(1));
        slot_dist = SLOT_W'(r_job.row - r0);
        slot0     = (r_job.slot >= slot_dist) ? r_job.slot - slot_dist
                    : r_job.slot + SLOT_W'(STORE_ROWS) - slot_dist;
        rem2      = {r_rem, r_dv[DIVD_W-1]};
    end

    assign o_job_ready          = (r_state == S_IDLE);
    assign o_res.valid          = r_out_v;
    assign o_res.out_row        = r_out_row;
    assign o_res.out_col        = r_out_col;
    assign o_res.variance_fixed = r_out_var;
    assign o_res.frame_last     = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    if (r_job.last_row) begin
                        r_r  <= (r_job.row >= ROW_W'(2)) ? r_job.row - ROW_W'(2) : '0;
                        r_rb <= r_job.row;
                    end else begin
                        r_r  <= r_job.row - ROW_W'(2);
                        r_rb <= r_job.row - ROW_W'(2);
                    end
                    if (r_job.last_col) begin
                        r_c  <= (r_job.col >= COL_W'(2)) ? r_job.col - COL_W'(2) : '0;
                        r_ca <= (r_job.col >= COL_W'(2)) ? r_job.col - COL_W'(2) : '0;
                        r_cb <= r_job.col;
                    end else begin
                        r_c  <= r_job.col - COL_W'(2);
                        r_ca <= r_job.col - COL_W'(2);
                        r_cb <= r_job.col - COL_W'(2);
                    end
                    if ((r_job.last_row || r_job.row >= ROW_W'(2)) &&
                        (r_job.last_col || r_job.col >= COL_W'(2))) begin
                        r_state <= S_SETUP;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SETUP: begin
                    r_y     <= r0;
                    r_yend  <= r1;
                    r_x     <= c0;
                    r_x0    <= c0;
                    r_x1    <= c1;
                    r_yslot <= slot0;
                    r_s     <= '0;
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_AC;
                end
                S_AC: begin
                    r_s   <= r_s + SUM_W'(rd_data);
                    r_q   <= r_q + SQ_W'({8'b0, rd_data} * {8'b0, rd_data});
                    r_cnt <= r_cnt + CNT_W'(1);
                    r_state <= S_RD;
                    if (r_x == r_x1) begin
                        r_x <= r_x0;
                        if (r_y == r_yend) begin
                            r_state <= S_MUL;
                        end else begin
                            r_y     <= r_y + ROW_W'(1);
                            r_yslot <= (r_yslot == SLOT_W'(STORE_ROWS - 1)) ? '0
                                       : r_yslot + SLOT_W'(1);
                        end
                    end else begin
                        r_x <= r_x + COL_W'(1);
                    end
                end
                S_MUL: begin
                    r_p1    <= NUM_W'(r_cnt) * NUM_W'(r_q);
                    r_p2    <= NUM_W'(r_s) * NUM_W'(r_s);
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_dv    <= {r_p1 - r_p2, {FRAC_BITS{1'b0}}};
                    r_den   <= DEN_W'(r_cnt) * DEN_W'(r_cnt - CNT_W'(1));
                    r_rem   <= '0;
                    r_it    <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (rem2 >= {1'b0, r_den}) begin
                        r_rem <= DEN_W'(rem2 - {1'b0, r_den});
                        r_dv  <= {r_dv[DIVD_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem2[DEN_W-1:0];
                        r_dv  <= {r_dv[DIVD_W-2:0], 1'b0};
                    end
                    r_it <= r_it + IT_W'(1);
                    if (r_it == IT_W'(DIVD_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_cnt < CNT_W'(2)) begin
                        r_out_var <= '0;
                    end else if (|r_dv[DIVD_W-1:VAR_W]) begin
                        r_out_var <= '1;
                    end else begin
                        r_out_var <= r_dv[VAR_W-1:0];
                    end
                    r_out_row  <= r_r;
                    r_out_col  <= r_c;
                    r_out_last <= (r_r == i_dims.height - ROW_W'(1)) &&
                                  ({1'b0, r_c} == i_dims.width - WID_W'(1));
                    r_out_v    <= 1'b1;
                    r_state    <= S_WAIT;
                end
                S_WAIT: begin
                    if (o_res.ready) begin
                        r_out_v <= 1'b0;
                        if (r_c == r_cb) begin
                            r_c <= r_ca;
                            if (r_r == r_rb) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_r     <= r_r + ROW_W'(1);
                                r_state <= S_SETUP;
                            end
                        end else begin
                            r_c     <= r_c + COL_W'(1);
                            r_state <= S_SETUP;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
